// ===== rtl/core/idq_pkg.sv =====
// Shared types, sizes and ring addressing for the indexed double-ended queue.
// Depends on nothing; the queue and its checker import it.
`default_nettype none

package idq_pkg;

   localparam int CAPACITY   = 1024;
   localparam int WORD_BITS  = 32;
   localparam int PTR_BITS   = $clog2(CAPACITY);
   localparam int CNT_BITS   = $clog2(CAPACITY + 1);
   localparam int SUM_BITS   = PTR_BITS + 1;
   localparam int INDEX_BITS = 10;
   localparam int CMP_BITS   = (CNT_BITS > INDEX_BITS) ? CNT_BITS : INDEX_BITS;

   typedef enum logic [2:0] {
      CMD_PUSH_BACK  = 3'd0,
      CMD_PUSH_FRONT = 3'd1,
      CMD_POP_BACK   = 3'd2,
      CMD_POP_FRONT  = 3'd3,
      CMD_GET        = 3'd4,
      CMD_SET        = 3'd5,
      CMD_CLEAR      = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_LOC  = 2'd1,
      STATUS_FULL     = 2'd2,
      STATUS_EMPTY    = 2'd3
   } status_type;

   // Ring position of a logical offset from the front, wrapping at CAPACITY.
   function automatic logic [PTR_BITS-1:0] ring_pos(input logic [PTR_BITS-1:0] front,
                                                    input logic [PTR_BITS-1:0] logical);
      logic [SUM_BITS-1:0] sum;
      sum = {1'b0, front} + {1'b0, logical};
      if (sum >= SUM_BITS'(CAPACITY)) begin
         sum = sum - SUM_BITS'(CAPACITY);
      end
      return sum[PTR_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/idq_ram.sv =====
// Single-port synchronous RAM with a registered read port, used as the ring store.
// Stand-alone; sized by its parameters.
`default_nettype none

module idq_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  wire logic                 clock,
   input  wire logic                 enable,
   input  wire logic                 write,
   input  wire logic [ADDR_BITS-1:0] address,
   input  wire logic [WIDTH-1:0]     write_data,
   output logic      [WIDTH-1:0]     read_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // The read register holds its word until the next read is issued.
   always_ff @(posedge clock) begin
      if (enable) begin
         if (write) begin
            mem[address] <= write_data;
         end else begin
            read_data_ff <= mem[address];
         end
      end
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/indexed_double_ended_queue.sv =====
// Indexed double-ended queue: one beat in, its response beat in the next cycle.
// One item per cycle unless the response stalls; at most one RAM access per item.
// A new request beat is taken whenever no response waits or the waiting one leaves.
// Synchronous active-high reset empties the queue and drops any pending response.
// The word store has no reset and needs no clearing pass.
`default_nettype none

module indexed_double_ended_queue (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_command,
   input  wire logic [9:0]  req_index,
   input  wire logic [31:0] req_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_read_value,
   output logic [1:0]       rsp_status,
   output logic [10:0]      rsp_count_after,
   output logic             rsp_is_empty
);
   import idq_pkg::*;

   // Ring state: position of logical index zero and the number of entries held.
   logic [PTR_BITS-1:0] front_ff, front_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   // Response register. The read word itself sits in the RAM's output register,
   // which only changes when a new request beat issues a read, so it stays put
   // for as long as the response is stalled.
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          status_ff, status_in;
   logic                get_ok_ff, get_ok_in;

   logic                accept;
   cmd_type             cmd;
   logic                full;
   logic                empty;
   logic                index_ok;
   logic [CMP_BITS-1:0] index_wide;
   logic [PTR_BITS-1:0] index_pos;

   logic                ram_enable;
   logic                ram_write;
   logic [PTR_BITS-1:0] ram_address;
   logic [WORD_BITS-1:0] ram_write_data;
   logic [WORD_BITS-1:0] ram_read_data;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign cmd       = cmd_type'(req_command);

   assign full       = (count_ff == CNT_BITS'(CAPACITY));
   assign empty      = (count_ff == '0);
   assign index_wide = CMP_BITS'(req_index);
   assign index_ok   = index_wide < CMP_BITS'(count_ff);
   assign index_pos  = ring_pos(front_ff, index_wide[PTR_BITS-1:0]);

   // Decode one request beat into the state update, the RAM access and the status.
   always_comb begin
      front_in       = front_ff;
      count_in       = count_ff;
      status_in      = STATUS_OK;
      get_ok_in      = 1'b0;
      ram_enable     = 1'b0;
      ram_write      = 1'b0;
      ram_address    = index_pos;
      ram_write_data = WORD_BITS'(req_value);
      case (cmd)
         CMD_PUSH_BACK: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               ram_enable  = 1'b1;
               ram_write   = 1'b1;
               ram_address = ring_pos(front_ff, count_ff[PTR_BITS-1:0]);
               count_in    = count_ff + 1'b1;
            end
         end
         CMD_PUSH_FRONT: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               front_in    = (front_ff == '0) ? PTR_BITS'(CAPACITY - 1) : front_ff - 1'b1;
               ram_enable  = 1'b1;
               ram_write   = 1'b1;
               ram_address = front_in;
               count_in    = count_ff + 1'b1;
            end
         end
         CMD_POP_BACK: begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         CMD_POP_FRONT: begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               front_in = ring_pos(front_ff, PTR_BITS'(1));
               count_in = count_ff - 1'b1;
            end
         end
         CMD_GET: begin
            if (!index_ok) begin
               status_in = STATUS_BAD_LOC;
            end else begin
               ram_enable = 1'b1;
               get_ok_in  = 1'b1;
            end
         end
         CMD_SET: begin
            if (!index_ok) begin
               status_in = STATUS_BAD_LOC;
            end else begin
               ram_enable = 1'b1;
               ram_write  = 1'b1;
            end
         end
         CMD_CLEAR: begin
            front_in = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   // A response is raised by an accepted beat and dropped once taken.
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            front_ff <= front_in;
            count_ff <= count_in;
         end
      end
   end

   // Payload of the response needs no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         get_ok_ff <= get_ok_in;
      end
   end

   idq_ram #(
      .DEPTH(CAPACITY),
      .WIDTH(WORD_BITS)
   ) u_ram (
      .clock      (clock),
      .enable     (accept && ram_enable),
      .write      (ram_write),
      .address    (ram_address),
      .write_data (ram_write_data),
      .read_data  (ram_read_data)
   );

   // The count register already holds the value after the item in the response.
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = get_ok_ff ? 32'(ram_read_data) : 32'd0;
   assign rsp_status      = status_ff;
   assign rsp_count_after = 11'(count_ff);
   assign rsp_is_empty    = (count_ff == '0);

endmodule

`default_nettype wire

// ===== rtl/core/idq_checker.sv =====
// Port-level checks for the indexed double-ended queue, bound to the top level.
// Depends on idq_pkg for the capacity and status codes.
`default_nettype none

module idq_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_read_value,
   input wire logic [1:0]  rsp_status,
   input wire logic [10:0] rsp_count_after,
   input wire logic        rsp_is_empty
);
   import idq_pkg::*;

   // Every accepted request beat gives a response beat in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request gave no response");

   // A stalled response keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_value)
         && $stable(rsp_status) && $stable(rsp_count_after))
      else $error("stalled response changed");

   // A dropped push is only reported with the queue full.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |-> rsp_count_after == 11'(CAPACITY))
      else $error("full status with room left");

   // An ignored pop is only reported with the queue empty.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |-> rsp_is_empty && rsp_count_after == '0)
      else $error("empty status with entries held");

   // A read word only comes with a successful item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_value != '0 |-> rsp_status == STATUS_OK)
      else $error("read word with failing status");

endmodule

bind indexed_double_ended_queue idq_checker u_idq_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_read_value  (rsp_read_value),
   .rsp_status      (rsp_status),
   .rsp_count_after (rsp_count_after),
   .rsp_is_empty    (rsp_is_empty)
);

`default_nettype wire
